[hw/rtl/cacp_pkg.sv]
package cacp_pkg;

    localparam int CNT_W = 16;
    localparam int DT_W = 10;

    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd1000;
    localparam logic [7:0]       DT_CODE_RST = 8'd0;
    localparam logic [CNT_W-1:0] INJ_CMP_RST = 16'd999;
    localparam logic [CNT_W-1:0] REG_CMP_RST = 16'd1;
    localparam logic [CNT_W-1:0] CMP_RST = PERIOD_RST / 2 + 16'd1;

    localparam logic [1:0] REG_PERIOD  = 2'd0;
    localparam logic [1:0] REG_DT_CODE = 2'd1;
    localparam logic [1:0] REG_INJ_CMP = 2'd2;
    localparam logic [1:0] REG_REG_CMP = 2'd3;

    localparam logic [1:0] GATE_OFF  = 2'b00;
    localparam logic [1:0] GATE_HIGH = 2'b01;
    localparam logic [1:0] GATE_LOW  = 2'b10;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             down;
        logic             upd;
    } tmr_t;

    function automatic logic [DT_W-1:0] decode_dead_time(input logic [7:0] code);
        logic [DT_W-1:0] ticks;
        case (code) inside
            8'b0???????: ticks = {3'b000, code[6:0]};
            8'b10??????: ticks = ({4'b0000, code[5:0]} + 10'd64) << 1;
            8'b110?????: ticks = ({5'b00000, code[4:0]} + 10'd32) << 3;
            default:     ticks = ({5'b00000, code[4:0]} + 10'd32) << 4;
        endcase
        return ticks;
    endfunction

    function automatic logic compare_ref(input logic [CNT_W-1:0] cnt, input logic down,
                                         input logic [CNT_W-1:0] cmp);
        return down ? (cnt <= cmp) : (cnt < cmp);
    endfunction

endpackage

[hw/rtl/center_aligned_complementary_pwm.sv]
// Counter step, three phase lanes and two trigger lanes are combinational; each
// accepted input yields one result, kept in a two-entry output buffer whose skid
// entry, when full, drops s_tready. Throughput otherwise: one item per cycle.
// Reset (aresetn low, synchronous): counter 0 counting up, compares period/2+1,
// gates off, break latch clear, registers at defaults, output buffer empty.
module center_aligned_complementary_pwm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // duty_a, duty_b, duty_c, outputs_enable, break_in, zero fill
    input  logic [55:0] s_tdata,
    // command
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // a_high, a_low, b_high, b_low, c_high, c_low, inj_trigger, reg_trigger,
    // update_event, break_flag, count, zero fill
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [cacp_pkg::CNT_W-1:0] period_reg, inj_cmp_reg, reg_cmp_reg;
    logic [7:0]                 dt_code_reg;
    logic                       latch_reg, latch_next;
    logic [31:0]                out_reg, skid_reg, res;
    logic                       out_valid_reg, skid_valid_reg;

    logic                       push, pop, load, tick, enable, brk, mask;
    logic [cacp_pkg::DT_W-1:0]  dead_ticks;
    cacp_pkg::tmr_t             tmr;
    logic [1:0]                 gate_a, gate_b, gate_c;
    logic                       inj_pulse, reg_pulse;

    assign s_tready = ~skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign push     = s_tvalid & s_tready;
    assign pop      = out_valid_reg & m_tready;
    assign load     = push & (s_tuser == cacp_pkg::CMD_LOAD);
    assign tick     = push & (s_tuser == cacp_pkg::CMD_TICK);
    assign enable   = s_tdata[48];
    assign brk      = s_tdata[49];
    assign dead_ticks = cacp_pkg::decode_dead_time(dt_code_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= cacp_pkg::PERIOD_RST;
            dt_code_reg <= cacp_pkg::DT_CODE_RST;
            inj_cmp_reg <= cacp_pkg::INJ_CMP_RST;
            reg_cmp_reg <= cacp_pkg::REG_CMP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cacp_pkg::REG_PERIOD:  period_reg  <= cfg_data;
                cacp_pkg::REG_DT_CODE: dt_code_reg <= cfg_data[7:0];
                cacp_pkg::REG_INJ_CMP: inj_cmp_reg <= cfg_data;
                cacp_pkg::REG_REG_CMP: reg_cmp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cacp_counter u_counter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .period  (period_reg),
        .tmr     (tmr)
    );

    cacp_phase_lane u_lane_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .tick       (tick),
        .duty       (s_tdata[15:0]),
        .period     (period_reg),
        .tmr        (tmr),
        .dead_ticks (dead_ticks),
        .gate_next  (gate_a)
    );

    cacp_phase_lane u_lane_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .tick       (tick),
        .duty       (s_tdata[31:16]),
        .period     (period_reg),
        .tmr        (tmr),
        .dead_ticks (dead_ticks),
        .gate_next  (gate_b)
    );

    cacp_phase_lane u_lane_c (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .tick       (tick),
        .duty       (s_tdata[47:32]),
        .period     (period_reg),
        .tmr        (tmr),
        .dead_ticks (dead_ticks),
        .gate_next  (gate_c)
    );

    cacp_trig_lane u_trig_inj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .tmr     (tmr),
        .cmp     (inj_cmp_reg),
        .pulse   (inj_pulse)
    );

    cacp_trig_lane u_trig_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .tmr     (tmr),
        .cmp     (reg_cmp_reg),
        .pulse   (reg_pulse)
    );

    // merge lanes: break and enable gating
    assign latch_next = brk | (enable & latch_reg);
    assign mask       = enable & ~latch_next;
    assign res = {6'd0, tmr.cnt, latch_next, tmr.upd, reg_pulse, inj_pulse,
                  gate_c & {2{mask}}, gate_b & {2{mask}}, gate_a & {2{mask}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= 1'b0;
        end else if (push) begin
            latch_reg <= latch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else if (!push) begin
                out_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= res;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

`ifndef SYNTH
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without head entry");
    a_break_gates: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg[9] |-> out_reg[5:0] == 6'd0)
        else $error("gates driven while break latched");
    a_update_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg[8] |-> out_reg[25:10] == '0)
        else $error("update event away from underflow");
    a_no_shoot_through: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg[0] && out_reg[1]) && !(out_reg[2] && out_reg[3])
                          && !(out_reg[4] && out_reg[5]))
        else $error("complementary gates both on");
`endif

endmodule

[hw/rtl/cacp_counter.sv]
module cacp_counter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       tick,
    input  logic [cacp_pkg::CNT_W-1:0] period,
    output cacp_pkg::tmr_t             tmr
);

    logic [cacp_pkg::CNT_W-1:0] cnt_reg;
    logic                       down_reg;
    logic [cacp_pkg::CNT_W-1:0] step;

    always_comb begin
        tmr.cnt  = cnt_reg;
        tmr.down = down_reg;
        tmr.upd  = 1'b0;
        if (tick) begin
            if (!down_reg) begin
                step = cnt_reg + 1'b1;
                tmr.cnt = step;
                tmr.down = (step >= period);
            end else begin
                step = cnt_reg - 1'b1;
                tmr.cnt = step;
                if (step == '0) begin
                    tmr.down = 1'b0;
                    tmr.upd  = 1'b1;
                end
            end
        end else begin
            step = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            down_reg <= 1'b0;
        end else begin
            cnt_reg  <= tmr.cnt;
            down_reg <= tmr.down;
        end
    end

endmodule

[hw/rtl/cacp_phase_lane.sv]
module cacp_phase_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic                       tick,
    input  logic [cacp_pkg::CNT_W-1:0] duty,
    input  logic [cacp_pkg::CNT_W-1:0] period,
    input  cacp_pkg::tmr_t             tmr,
    input  logic [cacp_pkg::DT_W-1:0]  dead_ticks,
    output logic [1:0]                 gate_next
);

    logic [cacp_pkg::CNT_W-1:0]   shd_reg, shd_next;
    logic [cacp_pkg::CNT_W-1:0]   act_reg, act_next;
    logic [cacp_pkg::DT_W-1:0]    dc_reg, dc_next;
    logic [1:0]                   gp_reg;
    logic                         prev_reg, prev_next;
    logic [2*cacp_pkg::CNT_W-1:0] prod;
    logic                         r;

    assign prod = duty * period;

    always_comb begin
        shd_next  = shd_reg;
        act_next  = act_reg;
        dc_next   = dc_reg;
        gate_next = gp_reg;
        prev_next = prev_reg;
        r         = 1'b0;
        if (load) begin
            shd_next = prod[2*cacp_pkg::CNT_W-1:cacp_pkg::CNT_W];
        end
        if (tick) begin
            if (tmr.upd) begin
                act_next = shd_reg;
            end
            r = cacp_pkg::compare_ref(tmr.cnt, tmr.down, act_next);
            if (r != prev_reg) begin
                gate_next = cacp_pkg::GATE_OFF;
                dc_next   = dead_ticks;
                prev_next = r;
            end
            if (dc_next == '0) begin
                gate_next = r ? cacp_pkg::GATE_HIGH : cacp_pkg::GATE_LOW;
            end else begin
                dc_next = dc_next - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shd_reg  <= cacp_pkg::CMP_RST;
            act_reg  <= cacp_pkg::CMP_RST;
            dc_reg   <= '0;
            gp_reg   <= cacp_pkg::GATE_OFF;
            prev_reg <= 1'b0;
        end else begin
            shd_reg  <= shd_next;
            act_reg  <= act_next;
            dc_reg   <= dc_next;
            gp_reg   <= gate_next;
            prev_reg <= prev_next;
        end
    end

`ifndef SYNTH
    a_gate_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        gp_reg != (cacp_pkg::GATE_HIGH | cacp_pkg::GATE_LOW))
        else $error("phase lane drives both gates");
    a_dead_blanks: assert property (@(posedge aclk) disable iff (!aresetn)
        dc_reg != '0 |-> gp_reg == cacp_pkg::GATE_OFF)
        else $error("gate on during dead time");
    a_gate_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !tick |=> gp_reg == $past(gp_reg))
        else $error("gate moved without a tick");
`endif

endmodule

[hw/rtl/cacp_trig_lane.sv]
module cacp_trig_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       tick,
    input  cacp_pkg::tmr_t             tmr,
    input  logic [cacp_pkg::CNT_W-1:0] cmp,
    output logic                       pulse
);

    logic prev_reg;
    logic r;

    assign r     = cacp_pkg::compare_ref(tmr.cnt, tmr.down, cmp);
    assign pulse = tick & r & ~prev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= 1'b0;
        end else if (tick) begin
            prev_reg <= r;
        end
    end

endmodule
